// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the divider RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define SDIV_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed: %m");

// check on every clock edge, reset included
`define SDIV_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("assertion failed: %m");

`else

`define SDIV_ASSERT(lbl, clk, rstn, prop)
`define SDIV_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/sdiv_pkg.sv
// ---------------------------------------------------------------------------
// sdiv_pkg
// Types and constants of the pipelined signed 32 by 16 divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdiv_pkg;

	// word geometry
	localparam int unsigned WORD_W      = 16;
	localparam int unsigned DVD_W       = 2 * WORD_W;
	// quotient bits resolved in one step stage, and the number of step stages
	localparam int unsigned STEPS_PER_STAGE = 4;
	localparam int unsigned STEP_STAGES     = WORD_W / STEPS_PER_STAGE;

	// magnitude of the most negative quotient that still fits
	localparam logic [WORD_W-1:0] Q_NEG_LIMIT = 16'h8000;

	// one request
	typedef struct packed {
		logic [WORD_W-1:0]        dividend_high;
		logic [WORD_W-1:0]        dividend_low;
		logic signed [WORD_W-1:0] divisor;
		logic                     negative_in;
		logic                     zero_in;
		logic                     carry_in;
	} req_t;

	// one result
	typedef struct packed {
		logic signed [WORD_W-1:0] quotient;
		logic signed [WORD_W-1:0] remainder;
		logic                     write_regs;
		logic                     negative_out;
		logic                     zero_out;
		logic                     overflow_out;
		logic                     carry_out;
	} rsp_t;

	// payload carried down the step stages
	typedef struct packed {
		logic [DVD_W-1:0]  rem;      // partial remainder magnitude
		logic [WORD_W-1:0] dmag;     // divisor magnitude
		logic [WORD_W-1:0] quo;      // quotient magnitude bits found so far
		logic              a_neg;    // dividend sign
		logic              d_neg;    // divisor sign
		logic              dz;       // divisor is zero
		logic              big;      // quotient magnitude at least 2^16
		logic              n_in;
		logic              z_in;
		logic              c_in;
	} stg_t;

endpackage

// File: rtl/sdiv_prep.sv
// ---------------------------------------------------------------------------
// sdiv_prep
// First stage: operand magnitudes, zero divisor and early overflow check.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdiv_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  sdiv_pkg::req_t     in_data,
	output logic               in_rdy,
	output logic               out_vld,
	output sdiv_pkg::stg_t     out_data,
	input  logic               out_rdy
);

	logic [sdiv_pkg::DVD_W-1:0]  dvd;
	logic [sdiv_pkg::DVD_W-1:0]  amag;
	logic [sdiv_pkg::WORD_W-1:0] dvs;
	logic [sdiv_pkg::WORD_W-1:0] dmag;
	sdiv_pkg::stg_t              nxt;
	logic                        vld_s1;
	sdiv_pkg::stg_t              stg_s1;

	// magnitudes of both operands
	always_comb begin
		dvd  = {in_data.dividend_high, in_data.dividend_low};
		amag = dvd[sdiv_pkg::DVD_W-1] ? (~dvd + 1'b1) : dvd;
		dvs  = in_data.divisor;
		dmag = dvs[sdiv_pkg::WORD_W-1] ? (~dvs + 1'b1) : dvs;
	end

	// early checks and initial partial remainder
	always_comb begin
		nxt       = '0;
		nxt.rem   = amag;
		nxt.dmag  = dmag;
		nxt.quo   = '0;
		nxt.a_neg = dvd[sdiv_pkg::DVD_W-1];
		nxt.d_neg = dvs[sdiv_pkg::WORD_W-1];
		nxt.dz    = (dmag == '0);
		// quotient needs more than 16 magnitude bits
		nxt.big   = ({1'b0, amag} >= {1'b0, dmag, {sdiv_pkg::WORD_W{1'b0}}});
		nxt.n_in  = in_data.negative_in;
		nxt.z_in  = in_data.zero_in;
		nxt.c_in  = in_data.carry_in;
	end

	assign in_rdy = !vld_s1 || out_rdy;

	// stage register, valid bit under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			stg_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_data = stg_s1;

endmodule

// File: rtl/sdiv_step.sv
// ---------------------------------------------------------------------------
// sdiv_step
// One step stage: STEPS_PER_STAGE restoring divide steps, then a register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdiv_step #(
	parameter int unsigned TOP_BIT = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  sdiv_pkg::stg_t     in_data,
	output logic               in_rdy,
	output logic               out_vld,
	output sdiv_pkg::stg_t     out_data,
	input  logic               out_rdy
);

	localparam int unsigned STEPS = sdiv_pkg::STEPS_PER_STAGE;
	localparam int unsigned WIN_W = sdiv_pkg::WORD_W + 1;

	sdiv_pkg::stg_t chain [STEPS+1];
	logic           vld_sn;
	sdiv_pkg::stg_t stg_sn;

	assign chain[0] = in_data;

	// restoring steps, quotient bit TOP_BIT downward
	for (genvar g = 0; g < STEPS; g++) begin : g_step
		localparam int unsigned B = TOP_BIT - g;
		logic [WIN_W-1:0] win;
		logic [WIN_W-1:0] dwin;
		sdiv_pkg::stg_t   nxt;

		always_comb begin
			nxt  = chain[g];
			win  = chain[g].rem[B +: WIN_W];
			dwin = {1'b0, chain[g].dmag};
			if (win >= dwin) begin
				nxt.rem[B +: WIN_W] = win - dwin;
				nxt.quo[B]          = 1'b1;
			end
		end

		assign chain[g+1] = nxt;
	end

	assign in_rdy = !vld_sn || out_rdy;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (in_rdy) begin
			vld_sn <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			stg_sn <= chain[STEPS];
		end
	end

	assign out_vld  = vld_sn;
	assign out_data = stg_sn;

endmodule

// File: rtl/sdiv_fin.sv
// ---------------------------------------------------------------------------
// sdiv_fin
// Last stage: sign fix-up, range check, flags and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdiv_fin (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  sdiv_pkg::stg_t     in_data,
	output logic               in_rdy,
	output logic               out_vld,
	output sdiv_pkg::rsp_t     out_data,
	input  logic               out_stall
);

	logic [sdiv_pkg::WORD_W-1:0] qm;
	logic [sdiv_pkg::WORD_W-1:0] rm;
	logic                        q_neg;
	logic                        q_range;
	sdiv_pkg::rsp_t              nxt;
	logic                        vld_s6;
	sdiv_pkg::rsp_t              rsp_s6;

	// result signs and the 16-bit range check
	always_comb begin
		qm      = in_data.quo;
		rm      = in_data.rem[sdiv_pkg::WORD_W-1:0];
		q_neg   = in_data.a_neg ^ in_data.d_neg;
		q_range = q_neg ? (qm > sdiv_pkg::Q_NEG_LIMIT) : qm[sdiv_pkg::WORD_W-1];
	end

	// flags and register write
	always_comb begin
		nxt = '0;
		if (in_data.dz) begin
			nxt.negative_out = in_data.n_in;
			nxt.zero_out     = in_data.z_in;
			nxt.overflow_out = 1'b1;
			nxt.carry_out    = 1'b1;
		end else if (in_data.big || q_range) begin
			nxt.negative_out = q_neg;
			nxt.zero_out     = in_data.z_in;
			nxt.overflow_out = 1'b1;
			nxt.carry_out    = in_data.c_in;
		end else begin
			nxt.quotient     = q_neg ? (~qm + 1'b1) : qm;
			nxt.remainder    = in_data.a_neg ? (~rm + 1'b1) : rm;
			nxt.write_regs   = 1'b1;
			nxt.negative_out = q_neg && (qm != '0);
			nxt.zero_out     = (qm == '0);
		end
	end

	assign in_rdy = !vld_s6 || !out_stall;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (in_rdy) begin
			vld_s6 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			rsp_s6 <= nxt;
		end
	end

	assign out_vld  = vld_s6;
	assign out_data = rsp_s6;

endmodule

// File: rtl/signed_divide_32_by_16_flags_unit.sv
// ---------------------------------------------------------------------------
// signed_divide_32_by_16_flags_unit
// Pipelined signed 32 by 16 divide with N, Z, V and C flag results.
// ---------------------------------------------------------------------------
//
//  channel   valid       stall       payload
//  request   req_valid   req_stall   req (sdiv_pkg::req_t)
//  result    rsp_valid   rsp_stall   rsp (sdiv_pkg::rsp_t)
//
// one request per cycle while req_stall is low; each result passes, in order,
// operand prep, four stages of four restoring steps, flag and result stage.
// the sixteen quotient bits, four per stage, set the pipeline depth.
// reset clears only the stage valid bits.
// a stalled result holds the pipe back stage by stage; bubbles still close up.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module signed_divide_32_by_16_flags_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sdiv_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output sdiv_pkg::rsp_t  rsp
);

	localparam int unsigned NS = sdiv_pkg::STEP_STAGES;

	logic           prep_rdy;
	logic           vld  [NS+1];
	logic           rdy  [NS+1];
	sdiv_pkg::stg_t data [NS+1];

	// operand prep
	sdiv_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (req_valid),
		.in_data  (req),
		.in_rdy   (prep_rdy),
		.out_vld  (vld[0]),
		.out_data (data[0]),
		.out_rdy  (rdy[0])
	);

	assign req_stall = !prep_rdy;

	// quotient step stages
	for (genvar k = 0; k < NS; k++) begin : g_stage
		sdiv_step #(
			.TOP_BIT (sdiv_pkg::WORD_W - 1 - k * sdiv_pkg::STEPS_PER_STAGE)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld[k]),
			.in_data  (data[k]),
			.in_rdy   (rdy[k]),
			.out_vld  (vld[k+1]),
			.out_data (data[k+1]),
			.out_rdy  (rdy[k+1])
		);
	end

	// flags and result register
	sdiv_fin u_fin (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld[NS]),
		.in_data   (data[NS]),
		.in_rdy    (rdy[NS]),
		.out_vld   (rsp_valid),
		.out_data  (rsp),
		.out_stall (rsp_stall)
	);

	// checks
	`SDIV_ASSERT(a_write_clears_vc, clk, arst_n, rsp_valid && rsp.write_regs |-> !rsp.overflow_out && !rsp.carry_out)
	`SDIV_ASSERT(a_v_iff_no_write, clk, arst_n, rsp_valid |-> rsp.overflow_out == !rsp.write_regs)
	`SDIV_ASSERT(a_no_write_zero, clk, arst_n, rsp_valid && !rsp.write_regs |-> rsp.quotient == 16'sd0 && rsp.remainder == 16'sd0)
	`SDIV_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !rsp_valid)

endmodule
